// ===== rtl/core/crba_pkg.sv =====
// Shared types and constants of the contiguous ring block allocator.
// Used by the channel interfaces, the step logic and the top level; depends on nothing.
`default_nettype none

package crba_pkg;

	localparam int MAX_RING_BYTES = 65536;

	// Fixed field widths of the request and response words.
	localparam int LEN_W = 17;
	localparam int RING_W = 17;
	localparam int OFF_W = 16;
	localparam int ST_W = 3;

	// Cursors never exceed the largest ring size.
	localparam int POS_W = $clog2(MAX_RING_BYTES + 1);
	localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

	localparam logic [RING_W-1:0] RING_BYTES_RESET = RING_W'(65536);

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE = 3'd1;
	localparam logic [ST_W-1:0] ST_NOT_OLDEST = 3'd2;
	localparam logic [ST_W-1:0] ST_PAST_END = 3'd3;
	localparam logic [ST_W-1:0] ST_PAST_WRITER = 3'd4;
	localparam logic [ST_W-1:0] ST_PAST_MARK = 3'd5;
	localparam logic [ST_W-1:0] ST_NOTHING_HELD = 3'd6;

	typedef struct packed {
		logic holding;
		logic [POS_W-1:0] read_pos;
		logic [POS_W-1:0] write_pos;
		logic tail_mark_valid;
		logic [POS_W-1:0] tail_mark;
	} ring_state_t;

	typedef struct packed {
		logic granted;
		logic [OFF_W-1:0] region_offset;
		logic [ST_W-1:0] status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/crba_ifs.sv =====
// Valid/ready channel interfaces for the allocator request and response words.
// Depends on crba_pkg for the field widths.
`default_nettype none

interface crba_req_if;
	import crba_pkg::*;

	logic valid;
	logic ready;
	logic action;
	logic [LEN_W-1:0] length;
	logic [LEN_W-1:0] release_offset;

	modport source (output valid, output action, output length, output release_offset,
		input ready);
	modport sink (input valid, input action, input length, input release_offset,
		output ready);
endinterface

interface crba_rsp_if;
	import crba_pkg::*;

	logic valid;
	logic ready;
	logic granted;
	logic [OFF_W-1:0] region_offset;
	logic [ST_W-1:0] status;

	modport source (output valid, output granted, output region_offset, output status,
		input ready);
	modport sink (input valid, input granted, input region_offset, input status,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crba_step.sv =====
// Combinational next-state and result logic for one allocate or release word.
// Depends on crba_pkg.
`default_nettype none

module crba_step (
	input  crba_pkg::ring_state_t cur,
	input  logic [crba_pkg::RING_W-1:0] ring_bytes,
	input  logic action,
	input  logic [crba_pkg::LEN_W-1:0] length,
	input  logic [crba_pkg::LEN_W-1:0] release_offset,
	output crba_pkg::ring_state_t nxt,
	output crba_pkg::result_t res
);
	import crba_pkg::*;

	logic [CMP_W-1:0] size;
	logic [CMP_W-1:0] len;
	logic [CMP_W-1:0] roff;
	logic [CMP_W-1:0] rp;
	logic [CMP_W-1:0] wp;
	logic [CMP_W-1:0] tm;
	logic [CMP_W-1:0] tail;
	logic [CMP_W-1:0] wp_end;
	logic [CMP_W-1:0] rd_end;
	logic [CMP_W-1:0] offset;
	logic ok;

	assign len = CMP_W'(length);
	assign roff = CMP_W'(release_offset);
	assign rp = CMP_W'(cur.read_pos);
	assign wp = CMP_W'(cur.write_pos);
	assign tm = CMP_W'(cur.tail_mark);
	assign wp_end = wp + len;
	assign rd_end = rp + len;
	assign tail = (size > wp) ? size - wp : '0;

	// Size 0 behaves as a one-byte ring; oversize values clamp to the maximum.
	always_comb begin
		if (ring_bytes == '0) begin
			size = CMP_W'(1);
		end else if (CMP_W'(ring_bytes) > CMP_W'(MAX_RING_BYTES)) begin
			size = CMP_W'(MAX_RING_BYTES);
		end else begin
			size = CMP_W'(ring_bytes);
		end
	end

	always_comb begin
		nxt = cur;
		res = '0;
		ok = 1'b0;
		offset = '0;
		if (action == ACT_ALLOC) begin
			if (!cur.holding) begin
				nxt.write_pos = '0;
				if (size >= len) begin
					ok = 1'b1;
					nxt.read_pos = '0;
					nxt.write_pos = POS_W'(len);
					nxt.holding = 1'b1;
				end
			end else if (rp >= wp) begin
				if (rp - wp >= len) begin
					ok = 1'b1;
					offset = wp;
					nxt.write_pos = POS_W'(wp_end);
				end
			end else if (tail >= len) begin
				ok = 1'b1;
				offset = wp;
				nxt.write_pos = POS_W'(wp_end);
			end else begin
				// Tail too short: mark it unused and wrap, even if the wrap fails.
				nxt.tail_mark = cur.write_pos;
				nxt.tail_mark_valid = 1'b1;
				nxt.write_pos = '0;
				if (rp > len) begin
					ok = 1'b1;
					nxt.write_pos = POS_W'(len);
				end
			end
			if (!ok) begin
				res.status = ST_NO_SPACE;
			end else if (offset > size) begin
				res.status = ST_PAST_END;
			end else begin
				res.granted = 1'b1;
				res.region_offset = offset[OFF_W-1:0];
				res.status = ST_OK;
			end
		end else begin
			if (!cur.holding) begin
				res.status = ST_NOTHING_HELD;
			end else if (roff > size) begin
				res.status = ST_PAST_END;
			end else if (roff != rp) begin
				res.status = ST_NOT_OLDEST;
			end else if (rd_end > size) begin
				res.status = ST_PAST_END;
			end else if (wp > rp && rd_end > wp) begin
				res.status = ST_PAST_WRITER;
			end else if (cur.tail_mark_valid && rd_end > tm) begin
				res.status = ST_PAST_MARK;
			end else begin
				res.granted = 1'b1;
				res.status = ST_OK;
				nxt.read_pos = POS_W'(rd_end);
				if (rd_end == wp) begin
					nxt = '0;
				end else if (cur.tail_mark_valid && rd_end == tm) begin
					nxt.tail_mark_valid = 1'b0;
					nxt.tail_mark = '0;
					if (cur.write_pos == '0) begin
						nxt = '0;
					end else begin
						nxt.read_pos = '0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/contiguous_ring_block_allocator_unit.sv =====
// Top level of the contiguous ring block allocator: input register, step logic, result register.
// Depends on crba_pkg, crba_ifs (channel interfaces) and crba_step.
//
// Usage:
//   req carries one word per request: action (allocate or release oldest), length and,
//   for a release, the offset of the region being handed back. rsp returns exactly one
//   word per request: granted, region_offset and status, in request order.
//   cfg_we/cfg_wdata set the ring size in bytes; write it only while no request is
//   outstanding. Zero acts as one byte, larger than the maximum clamps to the maximum.
//   A word accepted on req is captured in the input register, and its result is then
//   registered in the result register and shown on rsp from then on.
//   Throughput: one word per cycle while rsp is not stalled. The cursors are updated by a
//   single level of compares and adds between the input register and the result register,
//   so each word sees the state left by the word before it without any wait.
//   When rsp is stalled the result register holds its word and the input register
//   holds the next; req.ready drops only when both are full.
//   Reset empties the ring, clears both registers' valid flags and sets the ring
//   size to 65536 bytes.
`default_nettype none

module contiguous_ring_block_allocator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [crba_pkg::RING_W-1:0] cfg_wdata,
	crba_req_if.sink req,
	crba_rsp_if.source rsp
);
	import crba_pkg::*;

	logic [RING_W-1:0] ring_bytes_q;
	ring_state_t state_q;
	ring_state_t state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic out_valid_q;

	logic valid_s1;
	logic action_s1;
	logic [LEN_W-1:0] length_s1;
	logic [LEN_W-1:0] roff_s1;

	logic req_acc;
	logic advance;

	assign advance = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_acc = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_bytes_q <= RING_BYTES_RESET;
		end else if (cfg_we) begin
			ring_bytes_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			action_s1 <= req.action;
			length_s1 <= req.length;
			roff_s1 <= req.release_offset;
		end
	end

	crba_step u_step (
		.cur(state_q),
		.ring_bytes(ring_bytes_q),
		.action(action_s1),
		.length(length_s1),
		.release_offset(roff_s1),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.granted = res_q.granted;
	assign rsp.region_offset = res_q.region_offset;
	assign rsp.status = res_q.status;

	// An empty ring always has its cursors and tail mark cleared.
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.holding |-> (state_q.read_pos == '0 && state_q.write_pos == '0
			&& !state_q.tail_mark_valid))
		else $error("empty ring with stale cursors");

	// While a tail mark is set the writer has wrapped and sits at or behind the reader.
	a_mark_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.tail_mark_valid |-> (state_q.write_pos <= state_q.read_pos))
		else $error("tail mark set with writer ahead of reader");

	// A grant reports ok; a refusal reports a failure code and offset zero.
	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.granted ? (res_q.status == ST_OK)
			: (res_q.status != ST_OK && res_q.region_offset == '0)))
		else $error("grant flag and status disagree");

	// An accepted word is held in the input register at the next edge.
	a_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> valid_s1)
		else $error("accepted word lost");

endmodule

`default_nettype wire
